### rtl/core/chme_pkg.sv
// Shared types and codes for the chained hash map engine.
package chme_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MISSING  = 2'd1,
      ST_FULL     = 2'd2,
      ST_RESERVED = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_req;    // capture request beat
      logic init_step;    // write one init row (bucket and next link)
      logic init_start;   // reset init counter
      logic rd_head;      // read bucket head
      logic rd_entry;     // read key/item/next of cur
      logic advance;      // prev <= cur, cur <= next
      logic do_insert;    // write entry and link head
      logic unlink;       // splice cur out of its chain
      logic free_push;    // put cur back on the free list
      logic load_free;    // free_head <= next of old head
      logic set_result;   // capture response
      logic [1:0] res_sel; // 0 none/ok, 1 miss, 2 full, 3 hit
   } chme_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic init_done;
      logic cur_nil;
      logic key_match;
      logic pool_empty;
      logic prev_nil;
      logic walk_limit;
      op_type op;
   } chme_sts_type;

   localparam logic [1:0] RES_OK   = 2'd0;
   localparam logic [1:0] RES_MISS = 2'd1;
   localparam logic [1:0] RES_FULL = 2'd2;
   localparam logic [1:0] RES_HIT  = 2'd3;

endpackage

### rtl/core/chme_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module chme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/core/chme_datapath.sv
// Datapath: bucket, entry memories, free list, walk pointers, response register.
module chme_datapath #(
   parameter int BUCKETS  = 64,
   parameter int CAPACITY = 256,
   parameter int KEY_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_type,
   input  logic [31:0]             req_key,
   input  logic [31:0]             req_item,
   input  chme_pkg::chme_cmd_type  cmd,
   output chme_pkg::chme_sts_type  sts,
   output logic                    res_found,
   output logic [31:0]             res_item,
   output logic [1:0]              res_status
);
   import chme_pkg::*;

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int AW = $clog2(CAPACITY);
   localparam int LW = AW + 1;               // link width incl. null
   localparam int IW = (BW > AW) ? BW : AW;  // init counter index
   localparam logic [LW-1:0] NIL = LW'(CAPACITY);
   localparam int INIT_N = (BUCKETS > CAPACITY) ? BUCKETS : CAPACITY;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [31:0]         item_ff, item_in;
   op_type              op_ff, op_in;
   logic [BW-1:0]       bkt_ff, bkt_in;
   logic [LW-1:0]       cur_ff, cur_in, prev_ff, prev_in, free_ff, free_in;
   logic [IW:0]         init_ff, init_in;
   logic                found_ff, found_in;
   logic [31:0]         rit_ff, rit_in;
   logic [1:0]          rst_ff, rst_in;

   // memory ports
   logic           hd_we;
   logic [BW-1:0]  hd_wa, hd_ra;
   logic [LW-1:0]  hd_wd, hd_rd;
   logic           nx_we;
   logic [AW-1:0]  nx_wa, nx_ra;
   logic [LW-1:0]  nx_wd, nx_rd;
   logic           ent_we;
   logic [AW-1:0]  ent_ra;
   logic [KEY_BITS-1:0] k_rd;
   logic [31:0]    i_rd;

   logic [KEY_BITS-1:0] key_cut;
   logic [BW-1:0]       bkt_calc;

   assign key_cut  = KEY_BITS'(req_key);
   // bucket = key mod BUCKETS
   assign bkt_calc = BW'(key_cut % KEY_BITS'(BUCKETS));

   chme_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
      .clock, .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
      .rd_addr(hd_ra), .rd_data(hd_rd));
   chme_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
      .clock, .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_addr(nx_ra), .rd_data(nx_rd));
   chme_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key (
      .clock, .wr_en(ent_we), .wr_addr(free_ff[AW-1:0]), .wr_data(key_ff),
      .rd_addr(ent_ra), .rd_data(k_rd));
   chme_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_item (
      .clock, .wr_en(ent_we), .wr_addr(free_ff[AW-1:0]), .wr_data(item_ff),
      .rd_addr(ent_ra), .rd_data(i_rd));

   always_comb begin
      hd_we = 1'b0; hd_wa = bkt_ff; hd_wd = NIL; hd_ra = bkt_ff;
      nx_we = 1'b0; nx_wa = cur_ff[AW-1:0]; nx_wd = NIL;
      nx_ra = cur_ff[AW-1:0];
      ent_we = cmd.do_insert;
      ent_ra = cur_ff[AW-1:0];
      if (cmd.init_step) begin
         hd_we = (init_ff < (IW+1)'(BUCKETS));
         hd_wa = BW'(init_ff);
         nx_we = (init_ff < (IW+1)'(CAPACITY));
         nx_wa = AW'(init_ff);
         nx_wd = LW'(init_ff) + LW'(1);
      end else if (cmd.do_insert) begin
         // free_ff points to entry; cur holds old bucket head, prev takes the free next
         hd_we = 1'b1; hd_wd = free_ff;
         nx_we = 1'b1; nx_wa = free_ff[AW-1:0]; nx_wd = cur_ff;
      end else if (cmd.unlink) begin
         if (prev_ff == NIL) begin
            hd_we = 1'b1; hd_wd = nx_rd;
         end else begin
            nx_we = 1'b1; nx_wa = prev_ff[AW-1:0]; nx_wd = nx_rd;
         end
      end else if (cmd.free_push) begin
         nx_we = 1'b1; nx_wa = cur_ff[AW-1:0]; nx_wd = free_ff;
      end
      // an insert never walks, so the next-link port follows the free head
      if (op_ff == OP_INSERT) begin
         nx_ra = free_ff[AW-1:0];
      end
   end

   always_comb begin
      key_in = key_ff; item_in = item_ff; op_in = op_ff; bkt_in = bkt_ff;
      cur_in = cur_ff; prev_in = prev_ff; free_in = free_ff;
      init_in = init_ff;
      found_in = found_ff; rit_in = rit_ff; rst_in = rst_ff;
      if (cmd.latch_req) begin
         key_in = key_cut; item_in = req_item; op_in = op_type'(req_type);
         bkt_in = bkt_calc; prev_in = NIL;
      end
      if (cmd.init_start) init_in = '0;
      if (cmd.init_step) begin
         init_in = init_ff + 1'b1;
         free_in = '0;
      end
      if (cmd.rd_head) cur_in = hd_rd;
      if (cmd.advance) begin
         prev_in = cur_ff; cur_in = nx_rd;
      end
      if (cmd.load_free) free_in = prev_ff;
      if (cmd.do_insert) prev_in = nx_rd;
      if (cmd.free_push) free_in = cur_ff;
      if (cmd.set_result) begin
         found_in = (cmd.res_sel == RES_HIT);
         rit_in   = (cmd.res_sel == RES_HIT) ? i_rd : 32'd0;
         case (cmd.res_sel)
            RES_MISS: rst_in = ST_MISSING;
            RES_FULL: rst_in = ST_FULL;
            default:  rst_in = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
         free_ff <= '0;
         op_ff   <= OP_LOOKUP;
      end else begin
         init_ff <= init_in;
         free_ff <= free_in;
         op_ff   <= op_in;
      end
      key_ff <= key_in; item_ff <= item_in; bkt_ff <= bkt_in;
      cur_ff <= cur_in; prev_ff <= prev_in;
      found_ff <= found_in; rit_ff <= rit_in; rst_ff <= rst_in;
   end

   assign sts.init_done  = (init_ff >= (IW+1)'(INIT_N - 1));
   assign sts.cur_nil    = (cur_ff == NIL);
   assign sts.key_match  = (k_rd == key_ff);
   assign sts.pool_empty = (free_ff == NIL);
   assign sts.prev_nil   = (prev_ff == NIL);
   assign sts.walk_limit = 1'b0;
   assign sts.op         = op_ff;

   assign res_found  = found_ff;
   assign res_item   = rit_ff;
   assign res_status = rst_ff;
endmodule

### rtl/core/chme_ctrl.sv
// Controller state machine sequencing init, insert, walk and remove.
module chme_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [1:0]             req_type,
   input  chme_pkg::chme_sts_type sts,
   output chme_pkg::chme_cmd_type cmd
);
   import chme_pkg::*;

   typedef enum logic [10:0] {
      S_INIT   = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_HEAD   = 11'b00000000100,
      S_HWAIT  = 11'b00000001000,
      S_ENTRY  = 11'b00000010000,
      S_CHECK  = 11'b00000100000,
      S_INS    = 11'b00001000000,
      S_INS2   = 11'b00010000000,
      S_UNLINK = 11'b00100000000,
      S_FREE   = 11'b01000000000,
      S_RESP   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      acc;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign acc = req_valid && (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            // a clear answers after its sweep; the reset sweep does not
            if (sts.init_done) state_in = (sts.op == OP_CLEAR) ? S_RESP : S_IDLE;
         end
         S_IDLE: begin
            if (acc) begin
               cmd.latch_req = 1'b1;
               if (op_type'(req_type) == OP_CLEAR) begin
                  cmd.init_start = 1'b1;
                  state_in = S_INIT;
                  cmd.set_result = 1'b1; cmd.res_sel = RES_OK;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: state_in = S_HWAIT;       // head RAM read in flight
         S_HWAIT: begin
            cmd.rd_head = 1'b1;
            state_in = (sts.op == OP_INSERT) ? S_INS : S_ENTRY;
         end
         S_INS: begin
            // next link of the free head is read in this cycle
            if (sts.pool_empty) begin
               cmd.set_result = 1'b1; cmd.res_sel = RES_FULL;
               state_in = S_RESP;
            end else begin
               state_in = S_INS2;
            end
         end
         S_INS2: begin
            cmd.do_insert = 1'b1;
            state_in = S_FREE;
         end
         S_ENTRY: begin
            if (sts.cur_nil) begin
               cmd.set_result = 1'b1; cmd.res_sel = RES_MISS;
               state_in = S_RESP;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.key_match) begin
               cmd.set_result = 1'b1; cmd.res_sel = RES_HIT;
               state_in = (sts.op == OP_REMOVE) ? S_UNLINK : S_RESP;
            end else begin
               cmd.advance = 1'b1;
               state_in = S_ENTRY;
            end
         end
         S_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in = S_FREE;
         end
         S_FREE: begin
            if (sts.op == OP_INSERT) cmd.load_free = 1'b1;
            else cmd.free_push = 1'b1;
            if (sts.op == OP_INSERT) begin
               cmd.set_result = 1'b1; cmd.res_sel = RES_OK;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else       state_ff <= state_in;
   end
endmodule

### rtl/core/chained_hash_map_engine_unit.sv
// Top level of the chained hash map engine: controller plus datapath.
//
//  channel | direction | handshake           | fields
//  req     | in        | req_valid/req_stall | req_type, req_key, req_item
//  rsp     | out       | rsp_valid/rsp_stall | rsp_found, rsp_item_out, rsp_status
//
// An insert reads the bucket head and the free head's next link, then links
// the new entry at the head (ST_FULL if the pool is empty); a lookup walks the
// chain to a key match or its end, and a remove hit also unlinks and frees the
// entry. Each chain step is one read of the key, item and next-link RAMs.
// Reset and clear both run an init sweep over max(BUCKETS, CAPACITY) rows
// that rebuilds bucket heads and the free list; requests stall meanwhile.
// A clear answers once its sweep is done. One request in flight at a time;
// a stalled response holds the block until it is taken.
module chained_hash_map_engine_unit #(
   parameter int BUCKETS  = 64,
   parameter int CAPACITY = 256,
   parameter int KEY_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_key,
   input  logic [31:0] req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [31:0] rsp_item_out,
   output logic [1:0]  rsp_status
);
   import chme_pkg::*;

   chme_cmd_type cmd;
   chme_sts_type sts;

   chme_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .req_type, .sts, .cmd);

   chme_datapath #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS))
   u_dp (
      .clock, .reset, .req_type, .req_key, .req_item, .cmd, .sts,
      .res_found(rsp_found), .res_item(rsp_item_out), .res_status(rsp_status));
endmodule
